### rtl/fat16_sector_region_mapper_unit_macros.svh
// Assertion helpers for the sector region mapper.
`ifndef FAT16_SECTOR_REGION_MAPPER_UNIT_MACROS_SVH
`define FAT16_SECTOR_REGION_MAPPER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FSRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/fsrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fsrm_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_FAT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_DIR_SECTORS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SHIFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_TOTAL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_SECTORS   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [8:0]  RST_SECTORS_PER_FAT  = 9'd16;
  localparam logic [11:0] RST_ROOT_DIR_SECTORS = 12'd2;
  localparam logic [2:0]  RST_CLUSTER_SHIFT    = 3'd0;
  localparam logic [15:0] RST_CLUSTER_TOTAL    = 16'd4096;
  localparam logic [22:0] RST_VOLUME_SECTORS   = 23'd0;

  localparam logic [2:0]  MAX_SHIFT     = 3'd6;
  // Highest cluster count whose top index (count + 1) still fits 16 bits.
  localparam logic [15:0] MAX_CLUSTERS  = 16'hFFFE;
  localparam logic [15:0] CLUSTER_BASE  = 16'd2;

  typedef enum logic [2:0] {
    REGION_BOOT = 3'd0,
    REGION_FAT1 = 3'd1,
    REGION_FAT2 = 3'd2,
    REGION_ROOT = 3'd3,
    REGION_DATA = 3'd4,
    REGION_ZERO = 3'd5,
    REGION_PAST = 3'd6
  } region_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] first_sector;
    logic [6:0]  run_length;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sector_number;
    logic [2:0]  region;
    logic [11:0] region_offset;
    logic [15:0] cluster_number;
    logic [5:0]  cluster_sector;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic load;     // latch a new run
    logic calc;     // classify the current sector
    logic advance;  // step to the next sector
  } dp_cmd_t;

  typedef struct packed {
    logic run_empty;  // no sectors left in the run
    logic last;       // classified sector ends the run
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/fsrm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fsrm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output fsrm_pkg::dp_cmd_t     cmd,
  input  wire fsrm_pkg::dp_sts_t sts
);

  fsrm_pkg::state_t state_r;
  fsrm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsrm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state_r)
      fsrm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = fsrm_pkg::ST_LOAD;
        end
      end
      fsrm_pkg::ST_LOAD: begin
        state_nxt = sts.run_empty ? fsrm_pkg::ST_IDLE : fsrm_pkg::ST_CALC;
      end
      fsrm_pkg::ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = fsrm_pkg::ST_EMIT;
      end
      fsrm_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          state_nxt   = sts.last ? fsrm_pkg::ST_IDLE : fsrm_pkg::ST_CALC;
        end
      end
      default: begin
        state_nxt = fsrm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/fsrm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module fsrm_datapath #(
  parameter int unsigned MAX_RUN = 64,
  parameter int unsigned CW      = 7
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire fsrm_pkg::in_item_t               in_item,
  input  wire logic                             cfg_we,
  input  wire logic [fsrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fsrm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire fsrm_pkg::dp_cmd_t                cmd,
  output fsrm_pkg::dp_sts_t                     sts,
  output fsrm_pkg::out_item_t                   out_item
);

  // Configuration registers
  logic [8:0]  spf_r;
  logic [11:0] rds_r;
  logic [2:0]  shift_cfg_r;
  logic [15:0] ctotal_r;
  logic [22:0] vol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spf_r       <= fsrm_pkg::RST_SECTORS_PER_FAT;
      rds_r       <= fsrm_pkg::RST_ROOT_DIR_SECTORS;
      shift_cfg_r <= fsrm_pkg::RST_CLUSTER_SHIFT;
      ctotal_r    <= fsrm_pkg::RST_CLUSTER_TOTAL;
      vol_r       <= fsrm_pkg::RST_VOLUME_SECTORS;
    end else if (cfg_we) begin
      case (cfg_index)
        fsrm_pkg::CFG_SECTORS_PER_FAT:  spf_r       <= cfg_wdata[8:0];
        fsrm_pkg::CFG_ROOT_DIR_SECTORS: rds_r       <= cfg_wdata[11:0];
        fsrm_pkg::CFG_CLUSTER_SHIFT:    shift_cfg_r <= cfg_wdata[2:0];
        fsrm_pkg::CFG_CLUSTER_TOTAL:    ctotal_r    <= cfg_wdata[15:0];
        fsrm_pkg::CFG_VOLUME_SECTORS:   vol_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Region boundaries, refreshed every cycle from the configuration
  logic [9:0]  fat2_lba_r, fat2_lba_nxt;
  logic [10:0] root_lba_r, root_lba_nxt;
  logic [12:0] data_lba_r, data_lba_nxt;
  logic [22:0] data_end_r, data_end_nxt;
  logic [2:0]  shift_r, shift_nxt;
  logic [15:0] clu_lim;

  always_comb begin
    shift_nxt    = (shift_cfg_r > fsrm_pkg::MAX_SHIFT) ? fsrm_pkg::MAX_SHIFT : shift_cfg_r;
    fat2_lba_nxt = 10'(spf_r) + 10'd1;
    root_lba_nxt = 11'({spf_r, 1'b0}) + 11'd1;
    data_lba_nxt = 13'({spf_r, 1'b0}) + 13'(rds_r) + 13'd1;
    clu_lim      = (ctotal_r > fsrm_pkg::MAX_CLUSTERS) ? fsrm_pkg::MAX_CLUSTERS : ctotal_r;
    data_end_nxt = 23'(data_lba_nxt) + 23'(22'(clu_lim) << shift_nxt);
  end

  always_ff @(posedge clk) begin
    fat2_lba_r <= fat2_lba_nxt;
    root_lba_r <= root_lba_nxt;
    data_lba_r <= data_lba_nxt;
    data_end_r <= data_end_nxt;
    shift_r    <= shift_nxt;
  end

  // Run counter
  logic [31:0]   cur_sector_r, cur_sector_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [6:0]    run_clamped;

  assign run_clamped = (in_item.run_length > 7'(MAX_RUN)) ? 7'(MAX_RUN) : in_item.run_length;

  always_comb begin
    cur_sector_nxt = cur_sector_r;
    left_nxt       = left_r;
    if (cmd.load) begin
      cur_sector_nxt = in_item.first_sector;
      left_nxt       = CW'(run_clamped);
    end else if (cmd.advance) begin
      cur_sector_nxt = cur_sector_r + 32'd1;
      left_nxt       = left_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_sector_r <= '0;
      left_r       <= '0;
    end else begin
      cur_sector_r <= cur_sector_nxt;
      left_r       <= left_nxt;
    end
  end

  // Classify stage: boundary compares, registered on calc
  fsrm_pkg::region_t region_r, region_nxt;
  logic [11:0]       base_r, base_nxt;
  logic [21:0]       rel_r, rel_nxt;
  logic              last_r, last_nxt;
  logic              past_end;

  always_comb begin
    past_end   = cur_sector_r >= 32'(vol_r);
    base_nxt   = '0;
    rel_nxt    = cur_sector_r[21:0] - 22'(data_lba_r);
    last_nxt   = past_end || (left_r == CW'(1));
    if (past_end) begin
      region_nxt = fsrm_pkg::REGION_PAST;
    end else if (cur_sector_r == 32'd0) begin
      region_nxt = fsrm_pkg::REGION_BOOT;
    end else if (cur_sector_r < 32'(fat2_lba_r)) begin
      region_nxt = fsrm_pkg::REGION_FAT1;
      base_nxt   = 12'd1;
    end else if (cur_sector_r < 32'(root_lba_r)) begin
      region_nxt = fsrm_pkg::REGION_FAT2;
      base_nxt   = 12'(fat2_lba_r);
    end else if (cur_sector_r < 32'(data_lba_r)) begin
      region_nxt = fsrm_pkg::REGION_ROOT;
      base_nxt   = 12'(root_lba_r);
    end else if (cur_sector_r < 32'(data_end_r)) begin
      region_nxt = fsrm_pkg::REGION_DATA;
    end else begin
      region_nxt = fsrm_pkg::REGION_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      region_r <= region_nxt;
      base_r   <= base_nxt;
      rel_r    <= rel_nxt;
      last_r   <= last_nxt;
    end
  end

  // Format stage: offsets and cluster fields from the registered class
  logic        has_offset;
  logic        is_data;
  logic [5:0]  cs_mask;
  logic [21:0] rel_shifted;

  always_comb begin
    has_offset  = region_r inside {fsrm_pkg::REGION_FAT1, fsrm_pkg::REGION_FAT2,
                                   fsrm_pkg::REGION_ROOT};
    is_data     = region_r == fsrm_pkg::REGION_DATA;
    cs_mask     = 6'((7'd1 << shift_r) - 7'd1);
    rel_shifted = rel_r >> shift_r;

    out_item.sector_number  = cur_sector_r;
    out_item.region         = region_r;
    out_item.region_offset  = has_offset ? (cur_sector_r[11:0] - base_r) : 12'd0;
    out_item.cluster_number = is_data ? (rel_shifted[15:0] + fsrm_pkg::CLUSTER_BASE) : 16'd0;
    out_item.cluster_sector = is_data ? (rel_r[5:0] & cs_mask) : 6'd0;
    out_item.last           = last_r;
  end

  assign sts.run_empty = left_r == '0;
  assign sts.last      = last_r;

endmodule

`default_nettype wire

### rtl/fat16_sector_region_mapper_unit.sv
// FAT16 sector region mapper. A transaction on the input channel names a
// start sector and a run length (clamped to MAX_RUN, zero gives nothing);
// the block answers with one result transaction per sector of the run,
// classifying it as boot sector, FAT copy 1 or 2, root directory, data
// cluster (with cluster index from 2 and sector within the cluster), zero
// fill past the last cluster, or a past-end error that closes the run early.
// Sector numbers wrap at 32 bits; last marks the final result of a run.
// Timing: the block takes one run at a time. Accepting a run is followed by
// a setup state, then each sector goes through a compare state, which checks
// the sector against the region boundaries, and an emit state, which presents
// the formatted result until the sink takes it. A new run is accepted the
// cycle after its last result is taken. Write configuration only while no run
// is in flight; region boundaries are re-registered from the configuration
// registers after a write.
`timescale 1ns / 1ps
`default_nettype none

`include "fat16_sector_region_mapper_unit_macros.svh"

module fat16_sector_region_mapper_unit #(
  parameter int unsigned MAX_RUN = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire fsrm_pkg::in_item_t               in_item,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output fsrm_pkg::out_item_t                   out_item,
  // configuration writes
  input  wire logic                             cfg_we,
  input  wire logic [fsrm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [fsrm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Counter wide enough to hold the whole clamped run.
  localparam int unsigned CW = $clog2(MAX_RUN + 1);

  fsrm_pkg::dp_cmd_t cmd;
  fsrm_pkg::dp_sts_t sts;

  // Sequencer: accept, settle, then classify/emit per sector.
  fsrm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Config registers, run counter, boundary compare and result formatting.
  fsrm_datapath #(
    .MAX_RUN (MAX_RUN),
    .CW      (CW)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

  // A past-end error always closes the run.
  `FSRM_ASSERT_NOW(a_past_is_last,
                   out_valid && (out_item.region == fsrm_pkg::REGION_PAST),
                   out_item.last, "past-end result without last")

  // One run at a time: never ready for a request while a result is shown.
  `FSRM_ASSERT_NOW(a_one_run, in_ready, !out_valid, "request accepted while result pending")

  // Taking the final result returns the block to accepting requests.
  `FSRM_ASSERT_NEXT(a_last_frees, out_valid && out_ready && out_item.last, in_ready,
                    "block not free after last result")

  // Data clusters are numbered from two.
  `FSRM_ASSERT_NOW(a_cluster_base,
                   out_valid && (out_item.region == fsrm_pkg::REGION_DATA),
                   out_item.cluster_number >= fsrm_pkg::CLUSTER_BASE,
                   "data cluster below base")

endmodule

`default_nettype wire

### tb/sector_region_checker.sv
`timescale 1ns / 1ps

module sector_region_checker #(
  parameter int unsigned MAX_RUN = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  fsrm_pkg::in_item_t                  in_item,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  fsrm_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic [fsrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsrm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                  errors,
  output int                                  pending
);

  logic [8:0]  fat_len;
  logic [11:0] root_sectors;
  logic [2:0]  shift_cfg;
  logic [15:0] clus_cfg;
  logic [22:0] volume_size;

  fsrm_pkg::out_item_t expected_sectors[$];

  function automatic fsrm_pkg::out_item_t classify_sector(input logic [31:0] lba);
    logic [31:0] fat2_lba;
    logic [31:0] root_lba;
    logic [31:0] data_lba;
    logic [31:0] rel;
    logic [31:0] idx;
    logic [31:0] offset;
    logic [2:0]  sh;
    fsrm_pkg::out_item_t r;
    fat2_lba = 32'd1 + 32'(fat_len);
    root_lba = fat2_lba + 32'(fat_len);
    data_lba = root_lba + 32'(root_sectors);
    r = '0;
    r.sector_number = lba;
    offset = 32'd0;
    if (lba == 32'd0) begin
      r.region = fsrm_pkg::REGION_BOOT;
    end else if (lba < fat2_lba) begin
      r.region = fsrm_pkg::REGION_FAT1;
      offset = lba - 32'd1;
    end else if (lba < root_lba) begin
      r.region = fsrm_pkg::REGION_FAT2;
      offset = lba - fat2_lba;
    end else if (lba < data_lba) begin
      r.region = fsrm_pkg::REGION_ROOT;
      offset = lba - root_lba;
    end else begin
      sh  = (shift_cfg > fsrm_pkg::MAX_SHIFT) ? fsrm_pkg::MAX_SHIFT : shift_cfg;
      rel = lba - data_lba;
      idx = (rel >> sh) + 32'd2;
      if (idx >= ({16'd0, clus_cfg} + 32'd2) || idx > 32'h0000_FFFF) begin
        r.region = fsrm_pkg::REGION_ZERO;
      end else begin
        r.region         = fsrm_pkg::REGION_DATA;
        r.cluster_number = idx[15:0];
        rel              = rel & ((32'd1 << sh) - 32'd1);
        r.cluster_sector = rel[5:0];
      end
    end
    r.region_offset = offset[11:0];
    return r;
  endfunction

  // Expand one request into its per-sector results, stopping at the volume end.
  task automatic expand_run(input fsrm_pkg::in_item_t req);
    logic [31:0] lba;
    logic [6:0]  left;
    fsrm_pkg::out_item_t r;
    lba  = req.first_sector;
    left = req.run_length;
    if (left > MAX_RUN) left = 7'(MAX_RUN);
    while (left != 0) begin
      if (lba >= {9'd0, volume_size}) begin
        r = '0;
        r.sector_number = lba;
        r.region        = fsrm_pkg::REGION_PAST;
        r.last          = 1'b1;
        expected_sectors.push_back(r);
        left = 0;
      end else begin
        r    = classify_sector(lba);
        left = left - 7'd1;
        r.last = (left == 0);
        expected_sectors.push_back(r);
        lba  = lba + 32'd1;
      end
    end
  endtask

  task automatic check_sector(input fsrm_pkg::out_item_t got);
    fsrm_pkg::out_item_t want;
    if (expected_sectors.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result sector %h region %0d last %0b",
                 $realtime, got.sector_number, got.region, got.last);
    end else begin
      want = expected_sectors.pop_front();
      if (got.sector_number !== want.sector_number || got.region !== want.region ||
          got.region_offset !== want.region_offset ||
          got.cluster_number !== want.cluster_number ||
          got.cluster_sector !== want.cluster_sector || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display({"%0t: mismatch expected sector %h region %0d offset %0d ",
                    "cluster %0d csec %0d last %0b"},
                   $realtime, want.sector_number, want.region, want.region_offset,
                   want.cluster_number, want.cluster_sector, want.last);
          $display({"%0t:            got sector %h region %0d offset %0d ",
                    "cluster %0d csec %0d last %0b"},
                   $realtime, got.sector_number, got.region, got.region_offset,
                   got.cluster_number, got.cluster_sector, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fat_len      = fsrm_pkg::RST_SECTORS_PER_FAT;
      root_sectors = fsrm_pkg::RST_ROOT_DIR_SECTORS;
      shift_cfg    = fsrm_pkg::RST_CLUSTER_SHIFT;
      clus_cfg     = fsrm_pkg::RST_CLUSTER_TOTAL;
      volume_size  = fsrm_pkg::RST_VOLUME_SECTORS;
      expected_sectors.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fsrm_pkg::CFG_SECTORS_PER_FAT:  fat_len      = cfg_wdata[8:0];
          fsrm_pkg::CFG_ROOT_DIR_SECTORS: root_sectors = cfg_wdata[11:0];
          fsrm_pkg::CFG_CLUSTER_SHIFT:    shift_cfg    = cfg_wdata[2:0];
          fsrm_pkg::CFG_CLUSTER_TOTAL:    clus_cfg     = cfg_wdata[15:0];
          fsrm_pkg::CFG_VOLUME_SECTORS:   volume_size  = cfg_wdata[22:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_sector(out_item);
      if (in_valid && in_ready) expand_run(in_item);
    end
    pending = expected_sectors.size();
  end

endmodule

### tb/tb_fat16_sector_region_mapper_unit.sv
`timescale 1ns / 1ps

module tb_fat16_sector_region_mapper_unit;

  // Hard stop well beyond the slowest legal run (64 results per request,
  // long sink stalls and sender gaps all together).
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic clk;
  logic rst_n;

  logic                logic_unused_guard;
  logic                in_valid;
  logic                in_ready;
  fsrm_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  fsrm_pkg::out_item_t out_item;

  logic                            cfg_we;
  logic [fsrm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fsrm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int errors;
  int pending;

  // Idle percentages for the request sender and the result sink.
  int unsigned idle_pct;
  int unsigned stall_pct;

  // Mirror of the volume layout, used only to aim the stimulus at boundaries.
  int unsigned m_spf;
  int unsigned m_rds;
  int unsigned m_shift;
  int unsigned m_clusters;
  int unsigned m_vol;

  int unsigned cycles;
  int          seg;

  fat16_sector_region_mapper_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Watch both channels and the register port; predict and compare there.
  sector_region_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sink side: draw ready at random at the falling edge per the current stall rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Cycle counter: end the run if the regression hangs.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Offer one request. Insert random idle cycles first, then hold valid and
  // the payload until the transaction is taken at a rising edge. Valid stays
  // high afterwards; the next call either replaces the payload or drops valid.
  task automatic send_run(input logic [31:0] first, input logic [6:0] len);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid             <= 1'b1;
    in_item.first_sector <= first;
    in_item.run_length   <= len;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait until every predicted result has come back, then give
  // the block a few more cycles in case a zero-length run is still in flight.
  task automatic settle(input int unsigned tail);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  task automatic write_reg(input logic [fsrm_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[fsrm_pkg::CFG_DATA_W-1:0];
  endtask

  // Program the whole layout; only call this while the block is idle.
  task automatic apply_volume(input int unsigned spf, input int unsigned rds,
                              input int unsigned shift, input int unsigned clusters,
                              input int unsigned vol);
    write_reg(fsrm_pkg::CFG_SECTORS_PER_FAT, spf);
    write_reg(fsrm_pkg::CFG_ROOT_DIR_SECTORS, rds);
    write_reg(fsrm_pkg::CFG_CLUSTER_SHIFT, shift);
    write_reg(fsrm_pkg::CFG_CLUSTER_TOTAL, clusters);
    write_reg(fsrm_pkg::CFG_VOLUME_SECTORS, vol);
    @(negedge clk);
    cfg_we     <= 1'b0;
    m_spf      = spf & 32'h1FF;
    m_rds      = rds & 32'hFFF;
    m_shift    = shift & 32'h7;
    m_clusters = clusters & 32'hFFFF;
    m_vol      = vol & 32'h7F_FFFF;
  endtask

  // Pick a random layout, leaning on the edges: empty FAT or root regions,
  // the largest regions, out-of-range shift, zero and full cluster counts,
  // and a volume end placed near the end of the cluster area.
  task automatic random_volume();
    int unsigned spf;
    int unsigned rds;
    int unsigned shift;
    int unsigned clusters;
    int unsigned vol;
    int unsigned data_end;
    case ($urandom_range(0, 9))
      0:       spf = 0;
      1:       spf = 511;
      default: spf = $urandom_range(1, 256);
    endcase
    case ($urandom_range(0, 9))
      0:       rds = 0;
      1:       rds = 4095;
      default: rds = $urandom_range(1, 512);
    endcase
    shift = $urandom_range(0, 7);
    case ($urandom_range(0, 9))
      0:       clusters = 0;
      1:       clusters = 65535;
      2:       clusters = 4096;
      3:       clusters = 65524;
      default: clusters = $urandom_range(4096, 65524);
    endcase
    data_end = 1 + 2 * spf + rds +
               (clusters << ((shift > fsrm_pkg::MAX_SHIFT) ? fsrm_pkg::MAX_SHIFT : shift));
    case ($urandom_range(0, 9))
      0:       vol = 0;
      1:       vol = 32'h7F_FFFF;
      2:       vol = $urandom_range(0, 32'h7F_FFFF);
      default: begin
        vol = data_end + $urandom_range(0, 200);
        vol = (vol < 100) ? 0 : vol - 100;
        if (vol > 32'h7F_FFFF) vol = 32'h7F_FFFF;
      end
    endcase
    apply_volume(spf, rds, shift, clusters, vol);
  endtask

  // Aim start sectors at region edges, the end of the cluster area, the end
  // of the volume and the top of the 32-bit sector space.
  function automatic logic [31:0] pick_sector();
    logic [31:0] data_lba;
    logic [31:0] span;
    data_lba = 1 + 2 * m_spf + m_rds;
    span     = m_clusters <<
               ((m_shift > fsrm_pkg::MAX_SHIFT) ? fsrm_pkg::MAX_SHIFT : m_shift);
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, data_lba + 8);
      3, 4:    return data_lba + $urandom_range(0, span);
      5:       return data_lba + span - $urandom_range(0, 40);
      6:       return m_vol - $urandom_range(0, 40);
      7:       return $urandom_range(0, m_vol);
      8:       return $urandom();
      default: return 32'hFFFF_FFFF - $urandom_range(0, 40);
    endcase
  endfunction

  // Mostly short runs; some empty, full and over-long (clamped) ones.
  function automatic logic [6:0] pick_run_length();
    case ($urandom_range(0, 9))
      0:       return 7'd0;
      1:       return 7'($urandom_range(65, 127));
      2:       return 7'd64;
      default: return 7'($urandom_range(1, 24));
    endcase
  endfunction

  initial begin
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_index  = fsrm_pkg::CFG_SECTORS_PER_FAT;
    cfg_wdata  = '0;
    rst_n      = 1'b0;
    idle_pct   = 32;
    stall_pct  = 75;
    m_spf      = fsrm_pkg::RST_SECTORS_PER_FAT;
    m_rds      = fsrm_pkg::RST_ROOT_DIR_SECTORS;
    m_shift    = fsrm_pkg::RST_CLUSTER_SHIFT;
    m_clusters = fsrm_pkg::RST_CLUSTER_TOTAL;
    m_vol      = fsrm_pkg::RST_VOLUME_SECTORS;

    // Hold reset at the start, then release it for good.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset layout has an empty volume: every sector is past the end.
    send_run(32'd0, 7'd1);
    send_run(32'd0, 7'd0);
    settle(8);

    // Small regions, two sectors per cluster, largest volume.
    // Walk boot, both FAT copies, root and the first clusters; clamp a long
    // run; cross into zero fill; hit the volume end mid-run; start at the
    // top of the sector space.
    apply_volume(3, 4, 1, 4096, 32'h7F_FFFF);
    send_run(32'd0, 7'd64);
    send_run(32'd0, 7'd127);
    send_run(32'd8200, 7'd6);
    send_run(32'd8388605, 7'd5);
    send_run(32'hFFFF_FFFF, 7'd3);
    send_run(32'h8000_0000, 7'd1);
    settle(8);

    // Empty FAT and root regions, shift of seven (acts as six), all clusters.
    // The last run crosses the point where the cluster index leaves 16 bits.
    apply_volume(0, 0, 7, 65535, 32'h7F_FFFF);
    send_run(32'd0, 7'd8);
    send_run(32'd60, 7'd10);
    send_run(32'd4194174, 7'd6);
    settle(8);

    // Largest FAT and root regions, no clusters, short volume.
    apply_volume(511, 4095, 6, 0, 6000);
    send_run(32'd511, 7'd3);
    send_run(32'd1022, 7'd3);
    send_run(32'd5116, 7'd4);
    send_run(32'd5990, 7'd20);
    settle(8);

    // One sector per cluster: cross the last cluster, then the volume end.
    apply_volume(16, 32, 0, 4096, 4200);
    send_run(32'd4155, 7'd10);
    send_run(32'd4195, 7'd10);
    settle(8);

    // Random part: two layouts per idling phase. Swap the sender and sink
    // idle rates after the first pair, then drop idling altogether.
    for (seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        idle_pct  = 75;
        stall_pct = 32;
      end
      if (seg == 4) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      random_volume();
      repeat (50) send_run(pick_sector(), pick_run_length());
      settle(8);
    end

    // Let any stray output show up before the verdict.
    settle(16);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
